// ----- src/handshake_serial_link_assert.svh -----
// Assertion macros used by the checker of the serial link.
`ifndef HANDSHAKE_SERIAL_LINK_ASSERT_SVH
`define HANDSHAKE_SERIAL_LINK_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define HSL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("serial link check failed");

// Next-cycle implication, switched off while reset is high.
`define HSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("serial link check failed");

// Next-cycle implication that is also checked across reset.
`define HSL_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("serial link check failed");

`endif

// ----- src/hsl_pkg.sv -----
// Types and constants shared by the serial link modules.
`default_nettype none

package hsl_pkg;

   // Request kinds carried in req_tuser.
   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_READ  = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   // Status codes returned with every result item.
   typedef enum logic [1:0] {
      ST_OK            = 2'd0,
      ST_SEND_FULL     = 2'd1,
      ST_RECV_EMPTY    = 2'd2,
      ST_RECV_OVERFLOW = 2'd3
   } status_type;

   // Bit-sequencer phases: idle, data bits, then stop (transmit) or push (receive).
   localparam int unsigned PHASE_W = 4;
   localparam logic [PHASE_W-1:0] PH_IDLE  = 4'd0;
   localparam logic [PHASE_W-1:0] PH_FIRST = 4'd1;
   localparam logic [PHASE_W-1:0] PH_LAST  = 4'd9;

   // Field widths.
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned LEVEL_W = 5;
   localparam int unsigned DATA_W  = 16;
   localparam int unsigned USER_W  = 2;

   // Configuration register indexes.
   localparam logic CSR_ALMOST_FULL  = 1'b0;
   localparam logic CSR_ALMOST_EMPTY = 1'b1;

   // Reset values of the configuration registers.
   localparam logic [LEVEL_W-1:0] ALMOST_FULL_RESET  = 5'd14;
   localparam logic [LEVEL_W-1:0] ALMOST_EMPTY_RESET = 5'd2;

   // Bit positions in the data words.
   localparam int unsigned POS_LINE    = 0;
   localparam int unsigned POS_READY   = 1;
   localparam int unsigned POS_SENDING = 2;
   localparam int unsigned POS_BYTE    = 3;
   localparam int unsigned POS_STATUS  = 11;

   // Operations requested of a byte FIFO in one cycle.
   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctl_type;

endpackage

`default_nettype wire

// ----- src/hsl_fifo.sv -----
// Byte FIFO: circular buffer in a synchronous memory with head pointer and fill count.
`default_nettype none

module hsl_fifo #(
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire hsl_pkg::fifo_ctl_type               ctl,
   input  wire logic [hsl_pkg::BYTE_W-1:0]          wr_data,
   output logic      [$clog2(DEPTH+1)-1:0]          count,
   output logic      [hsl_pkg::BYTE_W-1:0]          rd_data
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH+1);
   localparam int unsigned SW = CW + 1;

   logic [hsl_pkg::BYTE_W-1:0] mem_ff [DEPTH];
   logic [hsl_pkg::BYTE_W-1:0] rd_data_ff;
   logic [AW-1:0]              head_ff, head_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [SW-1:0]              tail_sum;
   logic [AW-1:0]              tail;

   // The tail wraps at most once, so a single compare and subtract is enough.
   always_comb begin
      tail_sum = SW'(head_ff) + SW'(count_ff);
      if (tail_sum >= SW'(DEPTH)) begin
         tail = AW'(tail_sum - SW'(DEPTH));
      end else begin
         tail = AW'(tail_sum);
      end
   end

   // Pointer and fill count updates.
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctl.pop) begin
         if (head_ff == AW'(DEPTH - 1)) begin
            head_in = '0;
         end else begin
            head_in = head_ff + 1'b1;
         end
      end
      if (ctl.push && !ctl.pop) begin
         count_in = count_ff + 1'b1;
      end else if (ctl.pop && !ctl.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Storage: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem_ff[tail] <= wr_data;
      end
      if (ctl.pop) begin
         rd_data_ff <= mem_ff[head_ff];
      end
   end

   assign count   = count_ff;
   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/handshake_serial_link.sv -----
// Top level of the serial link: request decode, bit sequencers and result pipeline.
//
// The block moves bytes over a bit-serial line with ready and will-send flow control.
// Items arrive on the req_ channel: a bit tick (one transmit step, then one receive
// step), a host write that pushes a byte into the send FIFO, or a host read that pops
// a byte from the receive FIFO. Every item yields exactly one result on the rsp_
// channel carrying the line levels after the item, the popped byte and a status.
// Both FIFOs live in synchronous memories with a registered read port; the popped
// byte comes out of the memory read register on the cycle after acceptance.
// An accepted item passes the decode stage, then the output register, before it
// shows on rsp_tvalid. One item is accepted every cycle while rsp_tready stays high.
// When the receiver stalls, the output register and the decode stage each hold one
// item, so req_tready drops only once both are full.
// Reset (synchronous, active high) empties both FIFOs, idles the sequencers, drives
// the transmit and will-send lines low and the ready line high, and loads the
// almost-full and almost-empty levels with 14 and 2. FIFO memory is not cleared.
// The csr_ port writes a level register on any cycle with csr_we high; it is meant
// to be used only while the block is idle.
`default_nettype none

module handshake_serial_link #(
   parameter int unsigned FIFO_DEPTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // req_tdata: line_rx [0], partner_ready [1], partner_sending [2],
   // write_data [10:3], zero [15:11]
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [hsl_pkg::DATA_W-1:0]          req_tdata,
   // req_tuser: req_type [1:0]
   input  wire logic [hsl_pkg::USER_W-1:0]          req_tuser,
   // rsp_tdata: line_tx [0], ready_out [1], sending_out [2], read_data [10:3],
   // status [12:11], zero [15:13]
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [hsl_pkg::DATA_W-1:0]          rsp_tdata,
   input  wire logic                                csr_we,
   input  wire logic                                csr_index,
   input  wire logic [hsl_pkg::LEVEL_W-1:0]         csr_wdata
);

   localparam int unsigned CW    = $clog2(FIFO_DEPTH+1);
   localparam int unsigned CMP_W = ((CW > hsl_pkg::LEVEL_W) ? CW : hsl_pkg::LEVEL_W) + 1;

   // Request fields.
   logic                         accept;
   hsl_pkg::req_kind_type        req_kind;
   logic                         rx_bit;
   logic                         partner_ready;
   logic                         partner_sending;
   logic [hsl_pkg::BYTE_W-1:0]   write_data;

   // Configuration registers.
   logic [hsl_pkg::LEVEL_W-1:0]  almost_full_ff;
   logic [hsl_pkg::LEVEL_W-1:0]  almost_empty_ff;

   // Sequencer and line state.
   logic [hsl_pkg::PHASE_W-1:0]  tx_phase_ff, tx_phase_in;
   logic [hsl_pkg::PHASE_W-1:0]  rx_phase_ff, rx_phase_in;
   logic [hsl_pkg::BYTE_W-1:0]   tx_shift_ff, tx_shift_eff;
   logic                         tx_load_ff, tx_load_in;
   logic [hsl_pkg::BYTE_W-1:0]   rx_shift_ff, rx_shift_in;
   logic                         tx_level_ff, tx_level_in;
   logic                         ready_level_ff, ready_level_in;
   logic                         sending_level_ff, sending_level_in;
   logic [2:0]                   tx_bit_idx;
   logic [2:0]                   rx_bit_idx;

   // FIFO interfaces.
   hsl_pkg::fifo_ctl_type        send_ctl, recv_ctl;
   logic [CW-1:0]                send_count, recv_count;
   logic [hsl_pkg::BYTE_W-1:0]   send_rd_data, recv_rd_data;

   // Decode stage and output register.
   logic                         s1_valid_ff, s1_valid_in;
   logic                         s1_move;
   logic                         s1_line_ff, s1_ready_ff, s1_sending_ff, s1_rd_ff;
   hsl_pkg::status_type          s1_status_ff;
   hsl_pkg::status_type          status;
   logic                         rd_flag;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [hsl_pkg::DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [hsl_pkg::BYTE_W-1:0]   rsp_byte;

   // Unpack the request.
   assign req_kind        = hsl_pkg::req_kind_type'(req_tuser);
   assign rx_bit          = req_tdata[hsl_pkg::POS_LINE];
   assign partner_ready   = req_tdata[hsl_pkg::POS_READY];
   assign partner_sending = req_tdata[hsl_pkg::POS_SENDING];
   assign write_data      = req_tdata[hsl_pkg::POS_BYTE +: hsl_pkg::BYTE_W];

   // Handshake: the decode stage moves on whenever the output register is free.
   assign s1_move      = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !s1_valid_ff || s1_move;
   assign accept       = req_tvalid && req_tready;
   assign s1_valid_in  = accept || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_tready);

   // A byte popped for transmission lands in the memory read register in the cycle
   // after the pop; while tx_load_ff is set the shift value is taken from there.
   assign tx_shift_eff = tx_load_ff ? send_rd_data : tx_shift_ff;
   assign tx_bit_idx   = 3'(tx_phase_ff - hsl_pkg::PH_FIRST);
   assign rx_bit_idx   = 3'(rx_phase_ff - hsl_pkg::PH_FIRST);

   // Item processing: FIFO control, sequencers and line levels.
   always_comb begin
      tx_phase_in      = tx_phase_ff;
      rx_phase_in      = rx_phase_ff;
      rx_shift_in      = rx_shift_ff;
      tx_level_in      = tx_level_ff;
      ready_level_in   = ready_level_ff;
      sending_level_in = sending_level_ff;
      tx_load_in       = 1'b0;
      send_ctl         = '0;
      recv_ctl         = '0;
      status           = hsl_pkg::ST_OK;
      rd_flag          = 1'b0;
      if (accept) begin
         case (req_kind)
            hsl_pkg::REQ_TICK: begin
               // Transmit step.
               if (!partner_ready) begin
                  tx_level_in = 1'b0;
               end else if (tx_phase_ff == hsl_pkg::PH_IDLE) begin
                  if (send_count == '0) begin
                     sending_level_in = 1'b0;
                     tx_level_in      = 1'b0;
                  end else begin
                     send_ctl.pop     = 1'b1;
                     tx_load_in       = 1'b1;
                     sending_level_in = 1'b1;
                     tx_level_in      = 1'b1;
                     tx_phase_in      = hsl_pkg::PH_FIRST;
                  end
               end else if (tx_phase_ff >= hsl_pkg::PH_LAST) begin
                  tx_level_in = 1'b1;
                  tx_phase_in = hsl_pkg::PH_IDLE;
               end else begin
                  tx_level_in = tx_shift_eff[tx_bit_idx];
                  tx_phase_in = tx_phase_ff + 1'b1;
               end
               // Receive step.
               if (partner_sending) begin
                  if (rx_phase_ff == hsl_pkg::PH_IDLE) begin
                     if (rx_bit) begin
                        rx_phase_in = hsl_pkg::PH_FIRST;
                     end
                  end else if (rx_phase_ff >= hsl_pkg::PH_LAST) begin
                     if (CMP_W'(recv_count) >= CMP_W'(FIFO_DEPTH)) begin
                        status = hsl_pkg::ST_RECV_OVERFLOW;
                        if (CMP_W'(recv_count) >= CMP_W'(almost_full_ff)) begin
                           ready_level_in = 1'b0;
                        end
                     end else begin
                        recv_ctl.push = 1'b1;
                        if (CMP_W'(recv_count) + 1'b1 >= CMP_W'(almost_full_ff)) begin
                           ready_level_in = 1'b0;
                        end
                     end
                     rx_phase_in = hsl_pkg::PH_IDLE;
                     rx_shift_in = '0;
                  end else begin
                     rx_shift_in = rx_shift_ff |
                                   (hsl_pkg::BYTE_W'(rx_bit) << rx_bit_idx);
                     rx_phase_in = rx_phase_ff + 1'b1;
                  end
               end
            end
            hsl_pkg::REQ_WRITE: begin
               if (CMP_W'(send_count) >= CMP_W'(FIFO_DEPTH)) begin
                  status = hsl_pkg::ST_SEND_FULL;
               end else begin
                  send_ctl.push = 1'b1;
               end
            end
            hsl_pkg::REQ_READ: begin
               if (recv_count == '0) begin
                  status = hsl_pkg::ST_RECV_EMPTY;
               end else begin
                  recv_ctl.pop = 1'b1;
                  rd_flag      = 1'b1;
                  if (CMP_W'(recv_count) - 1'b1 <= CMP_W'(almost_empty_ff)) begin
                     ready_level_in = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Send and receive FIFOs.
   hsl_fifo #(
      .DEPTH   (FIFO_DEPTH)
   ) u_send_fifo (
      .clock   (clock),
      .reset   (reset),
      .ctl     (send_ctl),
      .wr_data (write_data),
      .count   (send_count),
      .rd_data (send_rd_data)
   );

   hsl_fifo #(
      .DEPTH   (FIFO_DEPTH)
   ) u_recv_fifo (
      .clock   (clock),
      .reset   (reset),
      .ctl     (recv_ctl),
      .wr_data (rx_shift_ff),
      .count   (recv_count),
      .rd_data (recv_rd_data)
   );

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         almost_full_ff   <= hsl_pkg::ALMOST_FULL_RESET;
         almost_empty_ff  <= hsl_pkg::ALMOST_EMPTY_RESET;
         tx_phase_ff      <= hsl_pkg::PH_IDLE;
         rx_phase_ff      <= hsl_pkg::PH_IDLE;
         rx_shift_ff      <= '0;
         tx_load_ff       <= 1'b0;
         tx_level_ff      <= 1'b0;
         ready_level_ff   <= 1'b1;
         sending_level_ff <= 1'b0;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_we && csr_index == hsl_pkg::CSR_ALMOST_FULL) begin
            almost_full_ff <= csr_wdata;
         end
         if (csr_we && csr_index == hsl_pkg::CSR_ALMOST_EMPTY) begin
            almost_empty_ff <= csr_wdata;
         end
         tx_phase_ff      <= tx_phase_in;
         rx_phase_ff      <= rx_phase_in;
         rx_shift_ff      <= rx_shift_in;
         tx_load_ff       <= tx_load_in;
         tx_level_ff      <= tx_level_in;
         ready_level_ff   <= ready_level_in;
         sending_level_ff <= sending_level_in;
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Transmit shift register and decode stage payload.
   always_ff @(posedge clock) begin
      tx_shift_ff <= tx_shift_eff;
      if (accept) begin
         s1_line_ff    <= tx_level_in;
         s1_ready_ff   <= ready_level_in;
         s1_sending_ff <= sending_level_in;
         s1_rd_ff      <= rd_flag;
         s1_status_ff  <= status;
      end
   end

   // Result packing; the popped byte comes from the receive memory read register.
   always_comb begin
      rsp_byte    = s1_rd_ff ? recv_rd_data : '0;
      rsp_data_in = '0;
      rsp_data_in[hsl_pkg::POS_LINE]                     = s1_line_ff;
      rsp_data_in[hsl_pkg::POS_READY]                    = s1_ready_ff;
      rsp_data_in[hsl_pkg::POS_SENDING]                  = s1_sending_ff;
      rsp_data_in[hsl_pkg::POS_BYTE +: hsl_pkg::BYTE_W]  = rsp_byte;
      rsp_data_in[hsl_pkg::POS_STATUS +: 2]              = s1_status_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- src/hsl_checker.sv -----
// Port-level checks of the serial link, bound to the top level.
`default_nettype none
`include "handshake_serial_link_assert.svh"

module hsl_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [hsl_pkg::DATA_W-1:0]     rsp_tdata
);

   logic                        line_tx;
   logic                        sending_out;
   logic [hsl_pkg::BYTE_W-1:0]  read_data;
   logic [1:0]                  status;
   logic                        req_accept;

   assign line_tx     = rsp_tdata[hsl_pkg::POS_LINE];
   assign sending_out = rsp_tdata[hsl_pkg::POS_SENDING];
   assign read_data   = rsp_tdata[hsl_pkg::POS_BYTE +: hsl_pkg::BYTE_W];
   assign status      = rsp_tdata[hsl_pkg::POS_STATUS +: 2];
   assign req_accept  = req_tvalid && req_tready;

   // A stalled result keeps its content.
   `HSL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))

   // The line can only be high while a byte is being sent.
   `HSL_ASSERT_IMP(a_line_needs_sending, clock, reset, rsp_tvalid && line_tx,
      sending_out)

   // A non-zero read byte only comes with a successful read.
   `HSL_ASSERT_IMP(a_byte_means_ok, clock, reset,
      rsp_tvalid && read_data != '0,
      status == hsl_pkg::ST_OK)

   // Nothing is offered on the cycle after reset, nor is an item refused in it.
   `HSL_ASSERT_ALWAYS(a_reset_clears, clock, reset,
      !rsp_tvalid && (req_accept == req_tvalid))

endmodule

bind handshake_serial_link hsl_checker u_hsl_checker (.*);

`default_nettype wire
